/* hdl/assert_macros.svh */
// ------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the ordered symbol set block.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define OSS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: assertion failed");

// Check that a condition is followed by another in the next cycle.
`define OSS_ASSERT_NEXT(label, clk, rst, cond, nxt) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) \
      else $error("%m: assertion failed");

`endif

/* hdl/oss_pkg.sv */
// ------------------------------------------------------------------------
// oss_pkg
// Types, codes and field widths shared by the ordered symbol set block.
// ------------------------------------------------------------------------
`default_nettype none

package oss_pkg;

   localparam int MODE_W           = 2;
   localparam int SYMBOL_W         = 8;
   localparam int INDEX_W          = 7;
   localparam int POSITION_W       = 7;
   localparam int COUNT_OUT_W      = 8;
   localparam int STATUS_W         = 3;
   localparam int DEFAULT_CAPACITY = 128;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_QUERY  = 2'd2,
      MODE_READ   = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE      = 3'd0,
      ST_PRESENT   = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_FULL      = 3'd3,
      ST_INDEX     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_EXEC,
      S_SHIFT,
      S_READ_ISSUE,
      S_READ_TAKE,
      S_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic latch;
      logic scan_run;
      logic exec;
      logic shift_run;
      logic shift_end;
      logic read_issue;
      logic read_take;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      mode_type mode;
      mode_type req_mode;
      logic     hit;
      logic     hit_now;
      logic     sweep_end;
      logic     idx_ok;
      logic     out_free;
   } stat_type;

endpackage

`default_nettype wire

/* hdl/oss_ram.sv */
// ------------------------------------------------------------------------
// oss_ram
// Generic single-write, single-read RAM with registered read data.
// ------------------------------------------------------------------------
`default_nettype none

module oss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/oss_ctrl.sv */
// ------------------------------------------------------------------------
// oss_ctrl
// Sequencer for the ordered symbol set: scan, execute, compact, read, emit.
// ------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module oss_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire oss_pkg::stat_type stat,
   output oss_pkg::cmd_type      cmd
);

   oss_pkg::state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= oss_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         oss_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = (stat.req_mode == oss_pkg::MODE_READ) ?
                           oss_pkg::S_READ_ISSUE : oss_pkg::S_SCAN;
            end
         end
         oss_pkg::S_SCAN: begin
            cmd.scan_run = 1'b1;
            if (stat.hit_now || stat.sweep_end) begin
               state_in = oss_pkg::S_EXEC;
            end
         end
         oss_pkg::S_EXEC: begin
            cmd.exec = 1'b1;
            if (stat.mode == oss_pkg::MODE_REMOVE && stat.hit) begin
               state_in = oss_pkg::S_SHIFT;
            end else begin
               state_in = oss_pkg::S_FINISH;
            end
         end
         oss_pkg::S_SHIFT: begin
            if (stat.sweep_end) begin
               cmd.shift_end = 1'b1;
               state_in      = oss_pkg::S_FINISH;
            end else begin
               cmd.shift_run = 1'b1;
            end
         end
         oss_pkg::S_READ_ISSUE: begin
            cmd.read_issue = 1'b1;
            state_in = stat.idx_ok ? oss_pkg::S_READ_TAKE : oss_pkg::S_FINISH;
         end
         oss_pkg::S_READ_TAKE: begin
            cmd.read_take = 1'b1;
            state_in      = oss_pkg::S_FINISH;
         end
         oss_pkg::S_FINISH: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = oss_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = oss_pkg::S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != oss_pkg::S_IDLE);

   `OSS_ASSERT_NEXT(a_accept_starts_work, clock, reset, cmd.latch,
      state_ff == oss_pkg::S_SCAN || state_ff == oss_pkg::S_READ_ISSUE)
   `OSS_ASSERT(a_shift_only_on_remove, clock, reset,
      state_ff != oss_pkg::S_SHIFT || stat.mode == oss_pkg::MODE_REMOVE)

endmodule

`default_nettype wire

/* hdl/oss_dp.sv */
// ------------------------------------------------------------------------
// oss_dp
// Datapath for the ordered symbol set: member RAM, sweep pointer, count
// and the result register.
// ------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module oss_dp #(
   parameter int CAPACITY = oss_pkg::DEFAULT_CAPACITY
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [oss_pkg::MODE_W-1:0]     req_mode,
   input  wire logic [oss_pkg::SYMBOL_W-1:0]   req_symbol,
   input  wire logic [oss_pkg::INDEX_W-1:0]    req_index,
   input  wire logic                           rsp_stall,
   output logic                                rsp_valid,
   output logic                                rsp_found,
   output logic      [oss_pkg::POSITION_W-1:0] rsp_position,
   output logic      [oss_pkg::SYMBOL_W-1:0]   rsp_element,
   output logic      [oss_pkg::COUNT_OUT_W-1:0] rsp_count,
   output logic      [oss_pkg::STATUS_W-1:0]   rsp_status,
   input  wire oss_pkg::cmd_type               cmd,
   output oss_pkg::stat_type                   stat
);

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (CNT_W > oss_pkg::INDEX_W) ? CNT_W : oss_pkg::INDEX_W;

   // Request fields and working state
   oss_pkg::mode_type              mode_ff, mode_in;
   logic [oss_pkg::SYMBOL_W-1:0]   symbol_ff, symbol_in;
   logic [oss_pkg::INDEX_W-1:0]    index_ff, index_in;
   logic [CNT_W-1:0]               count_ff, count_in;
   logic [CNT_W-1:0]               ptr_ff, ptr_in;
   logic                           pend_ff, pend_in;
   logic [ADDR_W-1:0]              rd_addr_ff, rd_addr_in;
   logic                           hit_ff, hit_in;
   logic [ADDR_W-1:0]              pos_ff, pos_in;
   logic [oss_pkg::SYMBOL_W-1:0]   element_ff, element_in;
   oss_pkg::status_type            status_ff, status_in;

   // Result register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_found_ff, rsp_found_in;
   logic [oss_pkg::POSITION_W-1:0] rsp_position_ff, rsp_position_in;
   logic [oss_pkg::SYMBOL_W-1:0]   rsp_element_ff, rsp_element_in;
   logic [oss_pkg::COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;
   oss_pkg::status_type            rsp_status_ff, rsp_status_in;

   // Memory ports
   logic                           wr_en;
   logic [ADDR_W-1:0]              wr_addr;
   logic [oss_pkg::SYMBOL_W-1:0]   wr_data;
   logic                           rd_en;
   logic [ADDR_W-1:0]              rd_addr;
   logic [oss_pkg::SYMBOL_W-1:0]   rd_data;

   logic                           hit_now;
   logic                           more;
   logic                           full;
   logic                           idx_ok;

   oss_ram #(
      .WIDTH (oss_pkg::SYMBOL_W),
      .DEPTH (CAPACITY)
   ) u_member_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign hit_now = pend_ff && (rd_data == symbol_ff);
   assign more    = (ptr_ff < count_ff);
   assign full    = (count_ff >= CNT_W'(CAPACITY));
   assign idx_ok  = (CMP_W'(index_ff) < CMP_W'(count_ff));

   // Report status to the controller
   always_comb begin
      stat.mode      = mode_ff;
      stat.req_mode  = oss_pkg::mode_type'(req_mode);
      stat.hit       = hit_ff;
      stat.hit_now   = hit_now;
      stat.sweep_end = !pend_ff && !more;
      stat.idx_ok    = idx_ok;
      stat.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   // Next values
   always_comb begin
      mode_in         = mode_ff;
      symbol_in       = symbol_ff;
      index_in        = index_ff;
      count_in        = count_ff;
      ptr_in          = ptr_ff;
      hit_in          = hit_ff;
      pos_in          = pos_ff;
      element_in      = element_ff;
      status_in       = status_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_found_in    = rsp_found_ff;
      rsp_position_in = rsp_position_ff;
      rsp_element_in  = rsp_element_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_status_in   = rsp_status_ff;
      wr_en           = 1'b0;
      wr_addr         = '0;
      wr_data         = '0;
      rd_en           = 1'b0;
      rd_addr         = '0;

      // Capture a new request
      if (cmd.latch) begin
         mode_in    = oss_pkg::mode_type'(req_mode);
         symbol_in  = req_symbol;
         index_in   = req_index;
         ptr_in     = '0;
         hit_in     = 1'b0;
         pos_in     = '0;
         element_in = '0;
         status_in  = oss_pkg::ST_DONE;
      end

      // Sweep the live members looking for the symbol
      if (cmd.scan_run) begin
         if (hit_now) begin
            hit_in = 1'b1;
            pos_in = rd_addr_ff;
         end
         if (more) begin
            rd_en   = 1'b1;
            rd_addr = ptr_ff[ADDR_W-1:0];
            ptr_in  = ptr_ff + 1'b1;
         end
      end

      // Apply the operation once the lookup is settled
      if (cmd.exec) begin
         unique case (mode_ff)
            oss_pkg::MODE_INSERT: begin
               if (full) begin
                  status_in = oss_pkg::ST_FULL;
               end else if (hit_ff) begin
                  status_in = oss_pkg::ST_PRESENT;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[ADDR_W-1:0];
                  wr_data  = symbol_ff;
                  count_in = count_ff + 1'b1;
               end
            end
            oss_pkg::MODE_REMOVE: begin
               if (!hit_ff) begin
                  status_in = oss_pkg::ST_NOT_FOUND;
               end else begin
                  ptr_in = CNT_W'(pos_ff) + 1'b1;
               end
            end
            oss_pkg::MODE_QUERY: begin
               if (!hit_ff) begin
                  status_in = oss_pkg::ST_NOT_FOUND;
               end
            end
            default: begin
               status_in = status_ff;
            end
         endcase
      end

      // Compact: move each later member down one place
      if (cmd.shift_run) begin
         if (pend_ff) begin
            wr_en   = 1'b1;
            wr_addr = rd_addr_ff - 1'b1;
            wr_data = rd_data;
         end
         if (more) begin
            rd_en   = 1'b1;
            rd_addr = ptr_ff[ADDR_W-1:0];
            ptr_in  = ptr_ff + 1'b1;
         end
      end
      if (cmd.shift_end) begin
         count_in = count_ff - 1'b1;
      end

      // Read the member at the requested index
      if (cmd.read_issue) begin
         if (idx_ok) begin
            rd_en   = 1'b1;
            rd_addr = ADDR_W'(index_ff);
         end else begin
            status_in = oss_pkg::ST_INDEX;
         end
      end
      if (cmd.read_take) begin
         element_in = rd_data;
      end

      // Load the result register, drop it once taken
      if (cmd.emit) begin
         rsp_valid_in    = 1'b1;
         rsp_found_in    = hit_ff;
         rsp_position_in = hit_ff ? oss_pkg::POSITION_W'(pos_ff) : '0;
         rsp_element_in  = element_ff;
         rsp_count_in    = oss_pkg::COUNT_OUT_W'(count_ff);
         rsp_status_in   = status_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign pend_in    = rd_en;
   assign rd_addr_in = rd_addr;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mode_ff         <= mode_in;
      symbol_ff       <= symbol_in;
      index_ff        <= index_in;
      ptr_ff          <= ptr_in;
      rd_addr_ff      <= rd_addr_in;
      hit_ff          <= hit_in;
      pos_ff          <= pos_in;
      element_ff      <= element_in;
      status_ff       <= status_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_position_ff <= rsp_position_in;
      rsp_element_ff  <= rsp_element_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_status_ff   <= rsp_status_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_element  = rsp_element_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_status   = rsp_status_ff;

   `OSS_ASSERT(a_count_in_range, clock, reset, count_ff <= CNT_W'(CAPACITY))
   `OSS_ASSERT(a_no_port_collision, clock, reset,
      !(wr_en && rd_en) || (wr_addr != rd_addr))

endmodule

`default_nettype wire

/* hdl/ordered_symbol_set_core.sv */
// ------------------------------------------------------------------------
// ordered_symbol_set_core
// Ordered set of distinct 8-bit symbols with insert, remove with
// compaction, membership query and indexed read.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    mode, symbol, index
//   rsp      out        rsp_valid/stall    found, position, element,
//                                          count, status
//
// Insert and query sweep the live members for the symbol; remove uses
// a shared sweep through the one-read, one-write member RAM for both
// lookup and compaction; read goes straight to the indexed member.
// One request is worked at a time; the result register lets the next
// request enter while the previous result waits on rsp_stall.
// Reset empties the set at once; no clearing pass runs on the RAM.
// ------------------------------------------------------------------------
`default_nettype none

module ordered_symbol_set_core #(
   parameter int CAPACITY = oss_pkg::DEFAULT_CAPACITY
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [oss_pkg::MODE_W-1:0]      req_mode,
   input  wire logic [oss_pkg::SYMBOL_W-1:0]    req_symbol,
   input  wire logic [oss_pkg::INDEX_W-1:0]     req_index,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic                                 rsp_found,
   output logic      [oss_pkg::POSITION_W-1:0]  rsp_position,
   output logic      [oss_pkg::SYMBOL_W-1:0]    rsp_element,
   output logic      [oss_pkg::COUNT_OUT_W-1:0] rsp_count,
   output logic      [oss_pkg::STATUS_W-1:0]    rsp_status
);

   oss_pkg::cmd_type  cmd;
   oss_pkg::stat_type stat;

   oss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   oss_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_mode     (req_mode),
      .req_symbol   (req_symbol),
      .req_index    (req_index),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_found    (rsp_found),
      .rsp_position (rsp_position),
      .rsp_element  (rsp_element),
      .rsp_count    (rsp_count),
      .rsp_status   (rsp_status),
      .cmd          (cmd),
      .stat         (stat)
   );

endmodule

`default_nettype wire

/* dv/tb_ordered_symbol_set_core.sv */
// ------------------------------------------------------------------------
// tb_ordered_symbol_set_core
// Self-checking bench for the ordered symbol set core. A scoreboard object
// mirrors the set contents, works out the response to every accepted
// request and compares it field by field with what the core returns.
// Stimulus is a short directed run over the corner cases followed by
// biased random phases that fill, drain and churn the set.
// ------------------------------------------------------------------------
`default_nettype none

module tb_ordered_symbol_set_core;

   timeunit 1ns;
   timeprecision 1ps;

   import oss_pkg::*;

   localparam int SET_CAPACITY = DEFAULT_CAPACITY;
   localparam int STALL_LIMIT  = 4000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 200;

   typedef enum {PHASE_FILL, PHASE_DRAIN, PHASE_MIXED} phase_type;

   typedef struct {
      bit                   found;
      bit [POSITION_W-1:0]  position;
      bit [SYMBOL_W-1:0]    element;
      bit [COUNT_OUT_W-1:0] count;
      status_type           status;
   } set_response_type;

   // Mirror of the set; predicts one response per accepted request.
   class set_scoreboard;
      bit [SYMBOL_W-1:0] members[SET_CAPACITY];
      int                live_count;
      set_response_type  expected_responses[$];
      int                mismatch_count;

      function new();
         live_count     = 0;
         mismatch_count = 0;
      endfunction

      function int pending();
         return expected_responses.size();
      endfunction

      function void note_request(mode_type mode, bit [SYMBOL_W-1:0] symbol,
                                 bit [INDEX_W-1:0] index);
         set_response_type rsp;
         bit               hit;
         int               pos;
         hit          = 1'b0;
         pos          = 0;
         rsp.element  = '0;
         rsp.status   = ST_DONE;
         // Linear lookup over the live members
         if (mode != MODE_READ) begin
            for (int i = 0; i < live_count; i++) begin
               if (!hit && members[i] == symbol) begin
                  hit = 1'b1;
                  pos = i;
               end
            end
         end
         case (mode)
            MODE_INSERT: begin
               if (live_count >= SET_CAPACITY) begin
                  rsp.status = ST_FULL;
               end else if (hit) begin
                  rsp.status = ST_PRESENT;
               end else begin
                  members[live_count] = symbol;
                  live_count++;
               end
            end
            MODE_REMOVE: begin
               if (!hit) begin
                  rsp.status = ST_NOT_FOUND;
               end else begin
                  // Compact: shift later members down one slot
                  for (int j = pos; j + 1 < live_count; j++)
                     members[j] = members[j + 1];
                  live_count--;
               end
            end
            MODE_QUERY: begin
               if (!hit) rsp.status = ST_NOT_FOUND;
            end
            default: begin
               if (index < live_count) rsp.element = members[index];
               else rsp.status = ST_INDEX;
            end
         endcase
         rsp.found    = hit;
         rsp.position = hit ? pos[POSITION_W-1:0] : '0;
         rsp.count    = live_count[COUNT_OUT_W-1:0];
         expected_responses.push_back(rsp);
      endfunction

      function void compare_field(string field, int expected, int actual);
         if (expected != actual) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, expected, actual);
            mismatch_count++;
         end
      endfunction

      function void check_response(bit found, bit [POSITION_W-1:0] position,
                                   bit [SYMBOL_W-1:0] element,
                                   bit [COUNT_OUT_W-1:0] count,
                                   bit [STATUS_W-1:0] status);
         set_response_type exp_rsp;
         if (expected_responses.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual status %0d",
                     $time, status);
            mismatch_count++;
         end else begin
            exp_rsp = expected_responses.pop_front();
            compare_field("found", exp_rsp.found, found);
            compare_field("position", exp_rsp.position, position);
            compare_field("element", exp_rsp.element, element);
            compare_field("count", exp_rsp.count, count);
            compare_field("status", int'(exp_rsp.status), status);
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [MODE_W-1:0]      req_mode = MODE_INSERT;
   logic [SYMBOL_W-1:0]    req_symbol = '0;
   logic [INDEX_W-1:0]     req_index = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_found;
   logic [POSITION_W-1:0]  rsp_position;
   logic [SYMBOL_W-1:0]    rsp_element;
   logic [COUNT_OUT_W-1:0] rsp_count;
   logic [STATUS_W-1:0]    rsp_status;

   bit quiet        = 1'b0;
   bit hold_request = 1'b0;
   int hold_left    = 0;
   int idle_cycles  = 0;

   set_scoreboard sb = new();

   ordered_symbol_set_core #(
      .CAPACITY(SET_CAPACITY)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_mode    (req_mode),
      .req_symbol  (req_symbol),
      .req_index   (req_index),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_found   (rsp_found),
      .rsp_position(rsp_position),
      .rsp_element (rsp_element),
      .rsp_count   (rsp_count),
      .rsp_status  (rsp_status)
   );

   // Generate the clock
   initial begin
      forever #6 clock = ~clock;
   end

   // Note every accepted request
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.note_request(mode_type'(req_mode), req_symbol, req_index);
   end

   // Check every accepted response
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_found, rsp_position, rsp_element, rsp_count, rsp_status);
   end

   // Drive response backpressure: random, quiet, or a long hold-off
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (quiet) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 26);
         end
      end
   end

   // Abort when no handshake completes for too long
   initial begin
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("ordered_symbol_set_core verification failed");
      $finish;
   end

   // Offer one request, with random idle cycles ahead of it, and hold it until taken
   task automatic send_request(input mode_type mode, input bit [SYMBOL_W-1:0] symbol,
                               input bit [INDEX_W-1:0] index);
      while (!quiet && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_mode   <= mode;
      req_symbol <= symbol;
      req_index  <= index;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Stop offering and wait for every outstanding response
   task automatic wait_for_responses();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Random requests biased toward growing, shrinking or churning the set
   task automatic run_phase(input phase_type kind, input int n_items);
      mode_type          mode;
      bit [SYMBOL_W-1:0] symbol;
      bit [INDEX_W-1:0]  index;
      int                roll;
      for (int k = 0; k < n_items; k++) begin
         roll = $urandom_range(99);
         case (kind)
            PHASE_FILL:
               mode = roll < 85 ? MODE_INSERT : roll < 90 ? MODE_REMOVE :
                      roll < 95 ? MODE_QUERY : MODE_READ;
            PHASE_DRAIN:
               mode = roll < 70 ? MODE_REMOVE : roll < 80 ? MODE_INSERT :
                      roll < 90 ? MODE_QUERY : MODE_READ;
            default:
               mode = mode_type'(roll % 4);
         endcase
         symbol = SYMBOL_W'($urandom_range(255));
         // Aim most removes and queries at live members
         if ((mode == MODE_REMOVE || mode == MODE_QUERY) && sb.live_count > 0 &&
             $urandom_range(99) < 60)
            symbol = sb.members[$urandom_range(sb.live_count - 1)];
         index = INDEX_W'($urandom_range(127));
         if (mode == MODE_READ && sb.live_count > 0 && $urandom_range(99) < 70)
            index = INDEX_W'($urandom_range(sb.live_count - 1));
         send_request(mode, symbol, index);
      end
   endtask

   // Main sequence
   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty-set reads and misses, duplicates, compaction
      send_request(MODE_READ,   8'h00, 7'd0);
      send_request(MODE_QUERY,  8'h00, 7'd0);
      send_request(MODE_REMOVE, 8'hFF, 7'd127);
      send_request(MODE_INSERT, 8'h00, 7'd0);
      send_request(MODE_INSERT, 8'hFF, 7'd127);
      send_request(MODE_INSERT, 8'h00, 7'd0);
      send_request(MODE_INSERT, 8'hA5, 7'd85);
      send_request(MODE_QUERY,  8'hFF, 7'd0);
      send_request(MODE_QUERY,  8'hA5, 7'd127);
      send_request(MODE_READ,   8'hFF, 7'd0);
      send_request(MODE_READ,   8'h00, 7'd2);
      send_request(MODE_READ,   8'h00, 7'd3);
      send_request(MODE_READ,   8'hFF, 7'd127);
      send_request(MODE_REMOVE, 8'h00, 7'd0);
      send_request(MODE_READ,   8'h00, 7'd0);
      send_request(MODE_REMOVE, 8'hA5, 7'd0);
      send_request(MODE_REMOVE, 8'hFF, 7'd0);
      send_request(MODE_INSERT, 8'h5A, 7'd42);
      send_request(MODE_QUERY,  8'h5A, 7'd0);
      send_request(MODE_REMOVE, 8'hFF, 7'd0);

      // Random: fill to capacity and keep inserting while full
      run_phase(PHASE_FILL, 260);

      // Hold off responses long enough to back the core up
      hold_request = 1'b1;
      run_phase(PHASE_MIXED, 150);

      // Pause until the pipeline is empty, then run with no idling
      wait_for_responses();
      quiet = 1'b1;
      run_phase(PHASE_MIXED, 150);
      quiet = 1'b0;

      run_phase(PHASE_DRAIN, 250);
      run_phase(PHASE_FILL, 150);
      run_phase(PHASE_MIXED, 140);

      // Drain and let any stray response show up
      wait_for_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.mismatch_count == 0 && sb.pending() == 0) begin
         $display("ordered_symbol_set_core verification clean");
      end else begin
         $display("ordered_symbol_set_core verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
